[rtl/core/rbt_pkg.sv]
// Package for the respawn backoff throttle: register map, codes, reset values
// and the shared config struct. No dependencies.

package rbt_pkg;

  // Default sizes handed to the top-level parameters
  localparam int SLOTS_DEF     = 32;
  localparam int TIME_BITS_DEF = 32;

  // Fixed part of a slot entry: running (1) + rapid count (8) + backoff (16)
  localparam int ENT_FIXED_W = 25;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_FAST_WINDOW  = 3'd0;
  localparam logic [2:0] REG_RAPID_LIMIT  = 3'd1;
  localparam logic [2:0] REG_MAX_BACKOFF  = 3'd2;
  localparam logic [2:0] REG_BASE_DELAY   = 3'd3;
  localparam logic [2:0] REG_SLOTS_IN_USE = 3'd4;

  localparam logic [15:0] RST_FAST_WINDOW  = 16'd90;
  localparam logic [7:0]  RST_RAPID_LIMIT  = 8'd5;
  localparam logic [14:0] RST_MAX_BACKOFF  = 15'd595;
  localparam logic [14:0] RST_BASE_DELAY   = 15'd5;
  localparam logic [5:0]  RST_SLOTS_IN_USE = 6'd0;

  // Request kinds
  localparam logic [1:0] K_CLEAR = 2'd0;
  localparam logic [1:0] K_START = 2'd1;
  localparam logic [1:0] K_EXIT  = 2'd2;
  localparam logic [1:0] K_WAKE  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_LAUNCHED  = 3'd0;
  localparam logic [2:0] ST_HELD      = 3'd1;
  localparam logic [2:0] ST_THROTTLED = 3'd2;
  localparam logic [2:0] ST_RUNNING   = 3'd3;
  localparam logic [2:0] ST_PAUSED    = 3'd4;
  localparam logic [2:0] ST_ACK       = 3'd5;

  // Rapid count limits
  localparam logic [7:0] RC_MAX = 8'hff;
  localparam logic [7:0] RC_DEC = 8'd2;

  typedef struct packed {
    logic [15:0] fast_window;
    logic [7:0]  rapid_limit;
    logic [14:0] max_backoff;
    logic [14:0] base_delay;
    logic [5:0]  slots_in_use;
  } cfg_t;

endpackage

[rtl/core/rbt_cfg.sv]
// Configuration register file behind the APB-style port.
// Depends on rbt_pkg (register map, reset values, cfg_t).

module rbt_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rbt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rbt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output rbt_pkg::cfg_t                  cfg
);

  rbt_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rbt_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_window  <= rbt_pkg::RST_FAST_WINDOW;
      cfg_r.rapid_limit  <= rbt_pkg::RST_RAPID_LIMIT;
      cfg_r.max_backoff  <= rbt_pkg::RST_MAX_BACKOFF;
      cfg_r.base_delay   <= rbt_pkg::RST_BASE_DELAY;
      cfg_r.slots_in_use <= rbt_pkg::RST_SLOTS_IN_USE;
    end else if (wr_en) begin
      unique case (reg_idx)
        rbt_pkg::REG_FAST_WINDOW:  cfg_r.fast_window  <= pwdata[15:0];
        rbt_pkg::REG_RAPID_LIMIT:  cfg_r.rapid_limit  <= pwdata[7:0];
        rbt_pkg::REG_MAX_BACKOFF:  cfg_r.max_backoff  <= pwdata[14:0];
        rbt_pkg::REG_BASE_DELAY:   cfg_r.base_delay   <= pwdata[14:0];
        rbt_pkg::REG_SLOTS_IN_USE: cfg_r.slots_in_use <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      rbt_pkg::REG_FAST_WINDOW:  prdata = {16'd0, cfg_r.fast_window};
      rbt_pkg::REG_RAPID_LIMIT:  prdata = {24'd0, cfg_r.rapid_limit};
      rbt_pkg::REG_MAX_BACKOFF:  prdata = {17'd0, cfg_r.max_backoff};
      rbt_pkg::REG_BASE_DELAY:   prdata = {17'd0, cfg_r.base_delay};
      rbt_pkg::REG_SLOTS_IN_USE: prdata = {26'd0, cfg_r.slots_in_use};
      default:                   prdata = '0;
    endcase
  end

endmodule

[rtl/core/rbt_mem.sv]
// Slot state memory: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.

module rbt_mem #(
  parameter int DEPTH = rbt_pkg::SLOTS_DEF,
  parameter int WIDTH = 2 * rbt_pkg::TIME_BITS_DEF + rbt_pkg::ENT_FIXED_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Valid bits: reset clears all, a write marks its entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[rtl/core/rbt_core.sv]
// Request sequencer and datapath: read-modify-write of one slot entry per
// request, plus the serial wake-delay scan. Depends on rbt_pkg.

module rbt_core #(
  parameter int SLOTS     = rbt_pkg::SLOTS_DEF,
  parameter int TIME_BITS = rbt_pkg::TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request side
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [4:0]               in_slot,
  input  logic [31:0]              in_now,
  input  logic                     in_paused,
  // result side
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_status,
  output logic [31:0]              out_next_start,
  output logic [31:0]              out_wake_delay,
  // configuration
  input  rbt_pkg::cfg_t            cfg,
  // state memory
  output logic                     mem_wr_en,
  output logic [$clog2(SLOTS)-1:0] mem_wr_addr,
  output logic [2*TIME_BITS+rbt_pkg::ENT_FIXED_W-1:0] mem_wr_data,
  output logic                     mem_rd_en,
  output logic [$clog2(SLOTS)-1:0] mem_rd_addr,
  input  logic [2*TIME_BITS+rbt_pkg::ENT_FIXED_W-1:0] mem_rd_data
);

  localparam int TB      = TIME_BITS;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int RC_LSB  = 16;
  localparam int NA_LSB  = 24;
  localparam int LS_LSB  = 24 + TB;
  localparam int RUN_BIT = 24 + 2 * TB;
  localparam logic [8:0] SLOT_LIM = 9'(SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EV1  = 3'd1;
  localparam logic [2:0] S_EV2  = 3'd2;
  localparam logic [2:0] S_WAKE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // request registers
  logic [1:0]       kind_r;
  logic             slot_ok_r;
  logic [IDX_W-1:0] idx_r;
  logic [TB-1:0]    now_r;
  logic [TB-1:0]    nowq_r;
  logic             paused_r;

  // working copy of the slot entry
  logic          run_r;
  logic [TB-1:0] ls_r;
  logic [TB-1:0] na_r;
  logic [7:0]    rc_r;
  logic [15:0]   bo_r;
  logic          held_r;
  logic          rapid_r;
  logic          thr_r;
  logic [14:0]   b_r;

  // wake scan
  logic [CNT_W-1:0] wk_cnt_r;
  logic [CNT_W-1:0] lim_r;
  logic             p1_r, p2_r;
  logic [TB-1:0]    diff_r;
  logic [TB-1:0]    best_r;
  logic             have_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_ns_r;
  logic [31:0] out_wake_r;

  // input decode
  logic [63:0]      now64;
  logic [TB-1:0]    now_in;
  logic [7:0]       slot8;
  logic [IDX_W-1:0] idx_in;
  logic             slot_ok_in;
  logic             accept;

  assign now64      = {32'd0, in_now};
  assign now_in     = now64[TB-1:0];
  assign slot8      = {3'd0, in_slot};
  assign idx_in     = slot8[IDX_W-1:0];
  assign slot_ok_in = {4'd0, in_slot} < SLOT_LIM;
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;

  // memory entry fields
  logic          m_run;
  logic [TB-1:0] m_ls;
  logic [TB-1:0] m_na;
  logic [7:0]    m_rc;
  logic [15:0]   m_bo;

  assign m_run = mem_rd_data[RUN_BIT];
  assign m_ls  = mem_rd_data[LS_LSB +: TB];
  assign m_na  = mem_rd_data[NA_LSB +: TB];
  assign m_rc  = mem_rd_data[RC_LSB +: 8];
  assign m_bo  = mem_rd_data[15:0];

  // hold window and rapid-restart tests on the entry just read
  logic [TB-1:0] hold_gap;
  logic [TB-1:0] since_last;
  logic          held_ev;
  logic          rapid_ev;

  assign hold_gap   = m_na + ~now_r;  // next_allowed - now - 1
  assign since_last = now_r - m_ls;
  assign held_ev    = hold_gap < {{(TB-15){1'b0}}, cfg.max_backoff};
  assign rapid_ev   = since_last[TB-1] ||
                      (since_last < {{(TB-16){1'b0}}, cfg.fast_window});

  // rapid count, backoff and throttle decision
  logic [7:0]  rc1;
  logic [15:0] bo1;
  logic [16:0] dbl;
  logic [15:0] mb16, bd16;
  logic [14:0] b_nxt;
  logic        thr_nxt;

  assign mb16 = {1'b0, cfg.max_backoff};
  assign bd16 = {1'b0, cfg.base_delay};

  always_comb begin
    if (rapid_r) begin
      rc1 = (rc_r == rbt_pkg::RC_MAX) ? rc_r : rc_r + 8'd1;
      bo1 = bo_r;
    end else begin
      rc1 = '0;
      bo1 = bd16;
    end
    thr_nxt = rc1 >= cfg.rapid_limit;
    dbl     = {bo1, 1'b0};
    if (bo1 >= mb16) begin
      b_nxt = cfg.max_backoff;
    end else if (bo1 < bd16) begin
      b_nxt = cfg.base_delay;
    end else if (dbl > {2'd0, cfg.max_backoff}) begin
      b_nxt = cfg.max_backoff;
    end else begin
      b_nxt = dbl[14:0];
    end
  end

  // new entry and result for the finishing step
  logic [TB-1:0] sum;
  logic          n_run;
  logic [TB-1:0] n_ls;
  logic [TB-1:0] n_na;
  logic [7:0]    n_rc;
  logic [15:0]   n_bo;
  logic [2:0]    n_status;
  logic [63:0]   ns64;
  logic [63:0]   wk64;
  logic          out_free;

  assign sum = now_r + (thr_r ? {{(TB-15){1'b0}}, b_r} : {{(TB-15){1'b0}}, cfg.base_delay});

  always_comb begin
    n_run    = run_r;
    n_ls     = ls_r;
    n_na     = na_r;
    n_rc     = rc_r;
    n_bo     = bo_r;
    n_status = rbt_pkg::ST_ACK;
    case (kind_r)
      rbt_pkg::K_CLEAR: begin
        n_run = 1'b0;
        n_ls  = '0;
        n_na  = now_r;
        n_rc  = '0;
        n_bo  = '0;
      end
      rbt_pkg::K_START: begin
        // a slot beyond the table is only acknowledged
        if (!slot_ok_r) begin
          n_status = rbt_pkg::ST_ACK;
        end else if (run_r) begin
          n_status = rbt_pkg::ST_RUNNING;
        end else if (paused_r) begin
          n_status = rbt_pkg::ST_PAUSED;
        end else if (held_r) begin
          n_status = rbt_pkg::ST_HELD;
        end else if (thr_r) begin
          n_status = rbt_pkg::ST_THROTTLED;
          n_na     = sum;
          n_ls     = sum;
          n_rc     = rc_r - rbt_pkg::RC_DEC;
          n_bo     = {1'b0, b_r};
        end else begin
          n_status = rbt_pkg::ST_LAUNCHED;
          n_na     = sum;
          n_run    = 1'b1;
        end
      end
      rbt_pkg::K_EXIT: begin
        n_run = 1'b0;
      end
      default: ;
    endcase
  end

  assign ns64     = slot_ok_r ? 64'(n_na) : 64'd0;
  assign wk64     = 64'(best_r);
  assign out_free = !out_valid_r || out_ready;

  // memory ports
  logic wk_issue;

  assign wk_issue    = (state_r == S_WAKE) && (wk_cnt_r < lim_r);
  assign mem_rd_en   = accept || wk_issue;
  assign mem_rd_addr = (state_r == S_IDLE) ? idx_in : wk_cnt_r[IDX_W-1:0];
  assign mem_wr_en   = (state_r == S_OUT) && out_free && slot_ok_r &&
                       (kind_r != rbt_pkg::K_WAKE);
  assign mem_wr_addr = idx_r;
  assign mem_wr_data = {n_run, n_ls, n_na, n_rc, n_bo};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EV1;
      S_EV1: begin
        if (kind_r == rbt_pkg::K_WAKE) begin
          state_nxt = S_WAKE;
        end else if (kind_r == rbt_pkg::K_START && !m_run && !paused_r && !held_ev) begin
          state_nxt = S_EV2;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_EV2:  state_nxt = S_OUT;
      S_WAKE: if (!wk_issue && !p1_r && !p2_r) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_kind;
      slot_ok_r <= slot_ok_in;
      idx_r     <= idx_in;
      now_r     <= now_in;
      nowq_r    <= (now_in == '0) ? {{(TB-1){1'b0}}, 1'b1} : now_in;
      paused_r  <= in_paused;
    end
  end

  // entry evaluation
  always_ff @(posedge clk) begin
    if (state_r == S_EV1) begin
      run_r   <= m_run;
      ls_r    <= m_ls;
      na_r    <= m_na;
      rc_r    <= m_rc;
      bo_r    <= m_bo;
      held_r  <= held_ev;
      rapid_r <= rapid_ev;
      thr_r   <= 1'b0;
    end else if (state_r == S_EV2) begin
      rc_r  <= rc1;
      bo_r  <= bo1;
      ls_r  <= rapid_r ? ls_r : now_r;
      thr_r <= thr_nxt;
      b_r   <= b_nxt;
    end
  end

  // wake scan: issue read, take difference, keep the minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r   <= 1'b0;
      p2_r   <= 1'b0;
      have_r <= 1'b0;
    end else if (state_r == S_EV1) begin
      p1_r   <= 1'b0;
      p2_r   <= 1'b0;
      have_r <= 1'b0;
    end else if (state_r == S_WAKE) begin
      p1_r <= wk_issue;
      p2_r <= p1_r;
      if (p2_r && (diff_r != '0) && !diff_r[TB-1] && (!have_r || diff_r < best_r)) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EV1) begin
      wk_cnt_r <= '0;
      lim_r    <= ({3'd0, cfg.slots_in_use} > SLOT_LIM) ? SLOT_LIM[CNT_W-1:0]
                                                        : CNT_W'(cfg.slots_in_use);
      best_r   <= '0;
    end else if (state_r == S_WAKE) begin
      if (wk_issue) begin
        wk_cnt_r <= wk_cnt_r + 1'b1;
      end
      if (p1_r) begin
        diff_r <= m_na - nowq_r;
      end
      if (p2_r && (diff_r != '0) && !diff_r[TB-1] && (!have_r || diff_r < best_r)) begin
        best_r <= diff_r;
      end
    end
  end

  // result register, loaded when the previous result has gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_status_r <= n_status;
      out_ns_r     <= ns64[31:0];
      out_wake_r   <= (kind_r == rbt_pkg::K_WAKE) ? wk64[31:0] : 32'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_next_start = out_ns_r;
  assign out_wake_delay = out_wake_r;

endmodule

[rtl/core/respawn_backoff_throttle.sv]
// Top level of the respawn backoff throttle: stream ports, APB config port.
// Depends on rbt_pkg, rbt_cfg, rbt_mem and rbt_core.

// One request at a time is processed against a per-slot state table held in
// a single synchronous memory (one read, one write port). Clear and exit
// requests pass through states S_EV1 and S_OUT before their result is loaded;
// start attempts that reach the backoff step pass through S_EV2 as well; a wake
// query walks min(slots_in_use, SLOTS) slots through the memory read port, one
// slot per cycle. The next request is accepted the cycle after a result is
// loaded into the output register, even if that result has not yet been taken.
// After reset every slot reads as all zero with no clearing pass; configuration
// may be written at any time the block is idle.

module respawn_backoff_throttle #(
  parameter int SLOTS     = rbt_pkg::SLOTS_DEF,
  parameter int TIME_BITS = rbt_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,   // slot[4:0], now[36:5], paused[37]
  input  logic [1:0]                     in_tuser,   // kind[1:0]
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // next_start[31:0], wake_delay[63:32]
  output logic [2:0]                     out_tuser,  // status[2:0]
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rbt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rbt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rbt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int ENT_W = 2 * TIME_BITS + rbt_pkg::ENT_FIXED_W;

  rbt_pkg::cfg_t    cfg;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [ENT_W-1:0] mem_rd_data;
  logic [31:0]      ns;
  logic [31:0]      wake;

  // Register file
  rbt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Slot state table
  rbt_mem #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Sequencer and datapath
  rbt_core #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_kind        (in_tuser),
    .in_slot        (in_tdata[4:0]),
    .in_now         (in_tdata[36:5]),
    .in_paused      (in_tdata[37]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (out_tuser),
    .out_next_start (ns),
    .out_wake_delay (wake),
    .cfg            (cfg),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  assign out_tdata = {wake, ns};

  // A read never targets the entry being written in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
    else $error("state memory read and write collide on one entry");

  // Every write-back goes with a result being presented
  a_wr_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |=> out_tvalid)
    else $error("state written without a result");

  // Only acknowledged results carry a wake delay
  a_wake_only_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != rbt_pkg::ST_ACK)) |-> (out_tdata[63:32] == 32'd0))
    else $error("wake delay on a start result");

  // No new request is taken in the cycle right after one was accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while one is in progress");

endmodule

[test/respawn_backoff_throttle_test.sv]
// Self-checking testbench for respawn_backoff_throttle: drives start, exit, clear and
// wake requests under several register settings and checks every result against
// its own model of the slot table. Depends on rbt_pkg and the RTL only.
`timescale 1ns / 1ps

module respawn_backoff_throttle_test;

  typedef struct {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [31:0] now;
    logic        paused;
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] next_start;
    logic [31:0] wake_delay;
  } res_t;

  localparam int NSLOT     = 32;
  localparam int STALL_LEN = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [rbt_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [rbt_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [rbt_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  respawn_backoff_throttle i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model copy of the registers
  logic [15:0] win_cfg   = rbt_pkg::RST_FAST_WINDOW;
  logic [7:0]  limit_cfg = rbt_pkg::RST_RAPID_LIMIT;
  logic [14:0] maxb_cfg  = rbt_pkg::RST_MAX_BACKOFF;
  logic [14:0] base_cfg  = rbt_pkg::RST_BASE_DELAY;
  logic [5:0]  used_cfg  = rbt_pkg::RST_SLOTS_IN_USE;

  // Model copy of the slot table, all zero after reset
  logic        slot_running [NSLOT];
  logic [31:0] slot_last    [NSLOT];
  logic [31:0] slot_next    [NSLOT];
  logic [7:0]  slot_rapid   [NSLOT];
  logic [15:0] slot_backoff [NSLOT];

  req_t queued_reqs[$];
  res_t due_results[$];
  req_t offered;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  logic stall_kick = 1'b0;
  logic stall_seen = 1'b0;
  int stall_left = 0;
  logic [31:0] t_cursor = '0;
  int unsigned step_caps[5] = '{3, 40, 200, 2000, 40000};

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      slot_running[i] = 1'b0;
      slot_last[i]    = '0;
      slot_next[i]    = '0;
      slot_rapid[i]   = '0;
      slot_backoff[i] = '0;
    end
  end

  // Start attempt against one slot; updates the table and returns the status
  function automatic logic [2:0] try_launch(int s, logic [31:0] now, logic paused);
    logic [31:0] d;
    logic [31:0] b;
    logic rapid;
    if (slot_running[s]) return rbt_pkg::ST_RUNNING;
    if (paused) return rbt_pkg::ST_PAUSED;
    d = slot_next[s] - now - 32'd1;
    if (d < {17'd0, maxb_cfg}) return rbt_pkg::ST_HELD;
    d = now - slot_last[s];
    rapid = d[31] || (d < {16'd0, win_cfg});
    if (rapid) begin
      if (slot_rapid[s] != rbt_pkg::RC_MAX) slot_rapid[s] = slot_rapid[s] + 8'd1;
    end else begin
      slot_rapid[s]   = '0;
      slot_last[s]    = now;
      slot_backoff[s] = {1'b0, base_cfg};
    end
    if (slot_rapid[s] >= limit_cfg) begin
      b = {16'd0, slot_backoff[s]};
      if (b >= {17'd0, maxb_cfg}) b = {17'd0, maxb_cfg};
      else if (b < {17'd0, base_cfg}) b = {17'd0, base_cfg};
      else begin
        b = b * 2;
        if (b > {17'd0, maxb_cfg}) b = {17'd0, maxb_cfg};
      end
      slot_backoff[s] = b[15:0];
      slot_next[s]    = now + b;
      slot_last[s]    = slot_next[s];
      slot_rapid[s]   = slot_rapid[s] - rbt_pkg::RC_DEC;
      return rbt_pkg::ST_THROTTLED;
    end
    slot_next[s]    = now + {17'd0, base_cfg};
    slot_running[s] = 1'b1;
    return rbt_pkg::ST_LAUNCHED;
  endfunction

  // Smallest positive gap from now to any next start among the slots in use
  function automatic logic [31:0] wake_gap(logic [31:0] now);
    int n;
    logic [31:0] t;
    logic [31:0] d;
    logic [31:0] best;
    logic have;
    n = (used_cfg > NSLOT) ? NSLOT : int'(used_cfg);
    t = (now == 0) ? 32'd1 : now;
    best = '0;
    have = 1'b0;
    for (int i = 0; i < n; i++) begin
      d = slot_next[i] - t;
      if (d != 0 && !d[31] && (!have || d < best)) begin
        best = d;
        have = 1'b1;
      end
    end
    return best;
  endfunction

  // Expected result of one request, applying its effect on the table
  function automatic res_t schedule_step(req_t r);
    res_t x;
    int s;
    s = r.slot;
    x.status = rbt_pkg::ST_ACK;
    x.wake_delay = '0;
    case (r.kind)
      rbt_pkg::K_WAKE:  x.wake_delay = wake_gap(r.now);
      rbt_pkg::K_CLEAR: begin
        slot_running[s] = 1'b0;
        slot_last[s]    = '0;
        slot_next[s]    = r.now;
        slot_rapid[s]   = '0;
        slot_backoff[s] = '0;
      end
      rbt_pkg::K_START: x.status = try_launch(s, r.now, r.paused);
      default: slot_running[s] = 1'b0;
    endcase
    x.next_start = slot_next[s];
    return x;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: %s mismatch: got 0x%08h, expected 0x%08h", $time, field, got, want);
  endtask

  // Request driver: offers queued requests, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) due_results.push_back(schedule_step(offered));
      if (!in_tvalid || in_tready) begin
        if (queued_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = queued_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, offered.paused, offered.now, offered.slot};
          in_tuser  <= offered.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted in cycles
  always @(posedge clk) begin
    if (stall_kick != stall_seen) begin
      stall_seen <= stall_kick;
      stall_left <= STALL_LEN;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          note_mismatch("unexpected result, next_start", out_tdata[31:0], '0);
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.status)
            note_mismatch("status", {29'd0, out_tuser}, {29'd0, want.status});
          if (out_tdata[31:0] !== want.next_start)
            note_mismatch("next_start", out_tdata[31:0], want.next_start);
          if (out_tdata[63:32] !== want.wake_delay)
            note_mismatch("wake_delay", out_tdata[63:32], want.wake_delay);
        end
      end
      if ((stall_kick != stall_seen) || (stall_left != 0)) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      rbt_pkg::REG_FAST_WINDOW: win_cfg   = val[15:0];
      rbt_pkg::REG_RAPID_LIMIT: limit_cfg = val[7:0];
      rbt_pkg::REG_MAX_BACKOFF: maxb_cfg  = val[14:0];
      rbt_pkg::REG_BASE_DELAY:  base_cfg  = val[14:0];
      default:                  used_cfg  = val[5:0];
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(int fw, int lim, int maxb, int base, int used);
    write_reg(rbt_pkg::REG_FAST_WINDOW, fw);
    write_reg(rbt_pkg::REG_RAPID_LIMIT, lim);
    write_reg(rbt_pkg::REG_MAX_BACKOFF, maxb);
    write_reg(rbt_pkg::REG_BASE_DELAY, base);
    write_reg(rbt_pkg::REG_SLOTS_IN_USE, used);
  endtask

  // Wait until nothing is queued, offered or outstanding, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (queued_reqs.size() != 0 || in_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic void queue_req(logic [1:0] kind, logic [4:0] slot, logic [31:0] now,
                                    logic paused);
    req_t r;
    r.kind   = kind;
    r.slot   = slot;
    r.now    = now;
    r.paused = paused;
    queued_reqs.push_back(r);
  endfunction

  // Mostly start/exit cycles on one slot with advancing time, some noise
  function automatic int add_episode();
    int n;
    int reps;
    logic [4:0] s;
    int unsigned cap;
    n = 0;
    if ($urandom_range(99) < 20) begin
      queue_req(2'($urandom_range(0, 3)), 5'($urandom), $urandom,
                1'($urandom_range(0, 1)));
      return 1;
    end
    cap  = step_caps[$urandom_range(0, 4)];
    s    = ($urandom_range(99) < 70) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
    reps = $urandom_range(2, 8);
    for (int i = 0; i < reps; i++) begin
      t_cursor = t_cursor + $urandom_range(0, cap);
      queue_req(rbt_pkg::K_START, s, t_cursor, $urandom_range(99) < 8);
      n++;
      if ($urandom_range(99) < 15) begin
        queue_req(rbt_pkg::K_WAKE, 5'($urandom), t_cursor + $urandom_range(0, 3),
                  1'($urandom_range(0, 1)));
        n++;
      end
      if ($urandom_range(99) < 75) begin
        queue_req(rbt_pkg::K_EXIT, s, t_cursor, 1'($urandom_range(0, 1)));
        n++;
      end
      if ($urandom_range(99) < 5) begin
        queue_req(rbt_pkg::K_CLEAR, s, t_cursor, 1'($urandom_range(0, 1)));
        n++;
      end
    end
    return n;
  endfunction

  initial begin
    int added;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset registers, empty wake, launch, running, held, throttling
    queue_req(rbt_pkg::K_WAKE, 5'd0, 32'd0, 1'b0);
    queue_req(rbt_pkg::K_CLEAR, 5'd31, 32'hffff_ffff, 1'b1);
    queue_req(rbt_pkg::K_CLEAR, 5'd0, 32'd0, 1'b0);
    queue_req(rbt_pkg::K_START, 5'd31, 32'd50, 1'b1);
    queue_req(rbt_pkg::K_START, 5'd0, 32'd100, 1'b0);
    queue_req(rbt_pkg::K_START, 5'd0, 32'd101, 1'b0);
    queue_req(rbt_pkg::K_EXIT, 5'd0, 32'd102, 1'b0);
    queue_req(rbt_pkg::K_START, 5'd0, 32'd103, 1'b0);
    for (int i = 0; i < 5; i++) begin
      queue_req(rbt_pkg::K_EXIT, 5'd0, 32'd110 + 6 * i, 1'b0);
      queue_req(rbt_pkg::K_START, 5'd0, 32'd110 + 6 * i, 1'b0);
    end
    queue_req(rbt_pkg::K_START, 5'd0, 32'd135, 1'b0);
    // last start lying after now counts as rapid
    queue_req(rbt_pkg::K_CLEAR, 5'd1, 32'd0, 1'b0);
    queue_req(rbt_pkg::K_START, 5'd1, 32'h8000_0000, 1'b0);
    drain();
    write_reg(rbt_pkg::REG_SLOTS_IN_USE, 32);
    // time zero is taken as one
    queue_req(rbt_pkg::K_WAKE, 5'd31, 32'd0, 1'b0);
    queue_req(rbt_pkg::K_WAKE, 5'd0, 32'd130, 1'b1);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 87 : 0;
      recv_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 27 : 0;
      case (ph)
        0: write_all(rbt_pkg::RST_FAST_WINDOW, rbt_pkg::RST_RAPID_LIMIT,
                     rbt_pkg::RST_MAX_BACKOFF, rbt_pkg::RST_BASE_DELAY, 32);
        1: write_all(0, 0, 1, 0, 1);
        2: write_all(65535, 255, 32767, 32767, 63);
        4: write_all(20, 2, 300, 3, 16);
        default: write_all($urandom_range(0, 400), $urandom_range(0, 8),
                           $urandom_range(1, 2000), $urandom_range(0, 60),
                           $urandom_range(0, 32));
      endcase
      t_cursor = (ph == 1) ? 32'hffff_f000 : $urandom;
      for (int half = 0; half < 2; half++) begin
        added = 0;
        while (added < 125) added += add_episode();
        // long receiver hold while requests keep coming
        if (half == 0 && (ph == 0 || ph == 4)) stall_kick = ~stall_kick;
        // sender pauses until every result is back
        if (half == 0) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/rbt_pkg.sv
rtl/core/rbt_cfg.sv
rtl/core/rbt_mem.sv
rtl/core/rbt_core.sv
rtl/core/respawn_backoff_throttle.sv
test/respawn_backoff_throttle_test.sv
